[hw/rtl/spq_pkg.sv]
package spq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int OCC_W = 4;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
    idx_prev = (idx == '0) ? IDX_LAST : idx - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
    idx_next = (idx == IDX_LAST) ? '0 : idx + 1'b1;
  endfunction

  // head plus count, wrapped once around the ring
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] cnt);
    logic [IDX_W+CNT_W-1:0] sum;
    sum = (IDX_W+CNT_W)'(base) + (IDX_W+CNT_W)'(cnt);
    if (sum >= (IDX_W+CNT_W)'(DEPTH)) begin
      sum = sum - (IDX_W+CNT_W)'(DEPTH);
    end
    idx_add = sum[IDX_W-1:0];
  endfunction

endpackage

[hw/rtl/spq_store.sv]
module spq_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [spq_pkg::IDX_W-1:0]  waddr,
  input  logic [spq_pkg::VAL_W-1:0]  wdata,
  input  logic [spq_pkg::IDX_W-1:0]  raddr,
  output logic [spq_pkg::VAL_W-1:0]  rdata
);
  import spq_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/sorted_priority_queue.sv]
// Min-first priority queue of up to DEPTH signed 32-bit values, kept sorted in a
// ring store with one write port, one registered read port and a moving head. A
// delete takes the head entry and offers its result from S_OUT after S_DEL; a
// delete from an empty queue or an insert into a full one offers the empty or full
// status in the cycle after acceptance and leaves the queue unchanged. An insert
// walks from the tail, moving each strictly larger entry up one slot per cycle and
// placing the new value after any equal ones, so its result passes through S_PUT
// into S_OUT for an empty queue and otherwise through S_RD, one S_CMP per entry
// compared and S_PUT; the store's one write and one registered read per cycle set
// that pace. The block takes one transaction at a time and is ready again once its
// result has been taken.
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic        s_tuser,   // action: 0 insert, 1 delete smallest
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], removed_value[33:2], occupancy[37:34], zero
);
  import spq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_PUT  = 6'b001000,
    S_DEL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  pos;
  logic [CNT_W-1:0]  remain;
  logic [VAL_W-1:0]  val;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  removed_value;
  logic [OCC_W-1:0]  occupancy;

  logic              we;
  logic [IDX_W-1:0]  raddr;
  logic [VAL_W-1:0]  wdata;
  logic [VAL_W-1:0]  rdata;
  logic              move_up;

  assign move_up = (state == S_CMP) && ($signed(val) < $signed(rdata));

  always_comb begin
    case (state)
      S_RD:    raddr = idx_prev(pos);
      S_CMP:   raddr = idx_prev(idx_prev(pos));  // prefetch for the next compare
      S_DEL:   raddr = head;
      default: raddr = head;
    endcase
  end

  assign we    = move_up || (state == S_PUT);
  assign wdata = (state == S_PUT) ? val : rdata;

  spq_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (pos),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            val           <= s_tdata;
            removed_value <= '0;
            status        <= ST_OK;
            occupancy     <= OCC_W'(count);
            pos           <= idx_add(head, count);
            remain        <= count;
            if (s_tuser) begin
              if (count == '0) begin
                status <= ST_EMPTY;
                state  <= S_OUT;
              end else begin
                state <= S_DEL;
              end
            end else if (count == CNT_W'(DEPTH)) begin
              status <= ST_FULL;
              state  <= S_OUT;
            end else if (count == '0) begin
              state <= S_PUT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (move_up) begin
            pos    <= idx_prev(pos);
            remain <= remain - 1'b1;
            if (remain == CNT_W'(1)) begin
              state <= S_PUT;
            end
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          count     <= count + 1'b1;
          occupancy <= OCC_W'(count + 1'b1);
          state     <= S_OUT;
        end
        S_DEL: begin
          state <= S_OUT;
          // head data arrives this cycle; close the gap by moving the head
          removed_value <= rdata;
          head          <= idx_next(head);
          count         <= count - 1'b1;
          occupancy     <= OCC_W'(count - 1'b1);
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {2'b00, occupancy, removed_value, status};

endmodule

[verif/sorted_priority_queue_test.sv]
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 313;
  localparam int HOLD_CYCLES = 250;
  localparam int TAIL_CYCLES = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIRECTED_N = 23;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  removed;
    logic [OCC_W-1:0]  occ;
  } queue_result_t;

  typedef struct packed {
    logic              act;
    logic [VAL_W-1:0]  val;
    logic              known;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  removed;
    logic [OCC_W-1:0]  occ;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = ACT_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  // sideband travelling with the offered transaction
  logic          row_known = 1'b0;
  queue_result_t row_result = '0;

  logic hold_off_req = 1'b0;
  bit   hold_done = 1'b0;

  logic signed [VAL_W-1:0] held_vals [DEPTH];
  int   held_count = 0;
  queue_result_t pending_outcomes [$];

  int errors = 0;
  int checked = 0;
  int n_insert = 0;
  int n_delete = 0;
  int n_full = 0;
  int n_empty = 0;
  int cycle_count = 0;

  op_row_t directed_ops [DIRECTED_N] = '{
    '{ACT_DELETE, 32'hDEADBEEF, 1'b1, ST_EMPTY, 32'h0, 4'd0},
    '{ACT_INSERT, 32'h7FFFFFFF, 1'b1, ST_OK, 32'h0, 4'd1},
    '{ACT_INSERT, 32'h80000000, 1'b1, ST_OK, 32'h0, 4'd2},
    '{ACT_INSERT, 32'h00000000, 1'b1, ST_OK, 32'h0, 4'd3},
    '{ACT_INSERT, 32'hFFFFFFFF, 1'b1, ST_OK, 32'h0, 4'd4},
    '{ACT_INSERT, 32'h00000005, 1'b0, ST_OK, 32'h0, 4'd0},
    '{ACT_INSERT, 32'h00000005, 1'b0, ST_OK, 32'h0, 4'd0},
    '{ACT_INSERT, 32'hFFFFFFFF, 1'b0, ST_OK, 32'h0, 4'd0},
    '{ACT_INSERT, 32'h55555555, 1'b1, ST_OK, 32'h0, 4'd8},
    '{ACT_INSERT, 32'hAAAAAAAA, 1'b1, ST_FULL, 32'h0, 4'd8},
    '{ACT_DELETE, 32'h00000000, 1'b1, ST_OK, 32'h80000000, 4'd7},
    '{ACT_DELETE, 32'hFFFFFFFF, 1'b0, ST_OK, 32'h0, 4'd0},
    '{ACT_DELETE, 32'h55555555, 1'b0, ST_OK, 32'h0, 4'd0},
    '{ACT_DELETE, 32'hAAAAAAAA, 1'b0, ST_OK, 32'h0, 4'd0},
    '{ACT_DELETE, 32'h12345678, 1'b0, ST_OK, 32'h0, 4'd0},
    '{ACT_DELETE, 32'h00000000, 1'b0, ST_OK, 32'h0, 4'd0},
    '{ACT_DELETE, 32'h00000000, 1'b0, ST_OK, 32'h0, 4'd0},
    '{ACT_DELETE, 32'h00000000, 1'b1, ST_OK, 32'h7FFFFFFF, 4'd0},
    '{ACT_DELETE, 32'hFFFFFFFF, 1'b1, ST_EMPTY, 32'h0, 4'd0},
    '{ACT_INSERT, 32'hAAAAAAAA, 1'b1, ST_OK, 32'h0, 4'd1},
    '{ACT_INSERT, 32'hAAAAAAAA, 1'b1, ST_OK, 32'h0, 4'd2},
    '{ACT_DELETE, 32'h00000000, 1'b1, ST_OK, 32'hAAAAAAAA, 4'd1},
    '{ACT_DELETE, 32'h00000000, 1'b1, ST_OK, 32'hAAAAAAAA, 4'd0}
  };

  sorted_priority_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // sorted insert after equal entries, delete from the head
  function automatic queue_result_t apply_queue_op(input logic act,
                                                   input logic signed [VAL_W-1:0] val);
    queue_result_t r;
    int pos;
    int i;
    r.status = ST_OK;
    r.removed = '0;
    if (act == ACT_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = held_count;
        while (pos > 0 && val < held_vals[pos-1]) begin
          held_vals[pos] = held_vals[pos-1];
          pos--;
        end
        held_vals[pos] = val;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed = held_vals[0];
      for (i = 1; i < held_count; i++) begin
        held_vals[i-1] = held_vals[i];
      end
      held_count--;
    end
    r.occ = OCC_W'(held_count);
    return r;
  endfunction

  // small values collide often, which exercises equal-key ordering
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h80000000;
          1: v = 32'h7FFFFFFF;
          2: v = 32'h00000000;
          default: v = 32'hFFFFFFFF;
        endcase
      end
      1, 2, 3: v = 32'($signed($urandom_range(0, 15)) - 8);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_op(input logic act, input logic [31:0] val, input logic known,
                         input queue_result_t res);
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= val;
    row_known <= known;
    row_result <= res;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic go_idle(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    queue_result_t predicted;
    queue_result_t want;
    queue_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predicted = apply_queue_op(s_tuser, s_tdata);
        pending_outcomes.push_back(row_known ? row_result : predicted);
        if (s_tuser == ACT_INSERT) n_insert++;
        else n_delete++;
      end
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.removed = m_tdata[33:2];
        got.occ = m_tdata[37:34];
        if (got.status == ST_FULL) n_full++;
        if (got.status == ST_EMPTY) n_empty++;
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected transaction, status %0d removed %h occupancy %0d",
                   $time, got.status, got.removed, got.occ);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          checked++;
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.removed != want.removed) begin
            $display("%0t: removed_value expected %h actual %h", $time, want.removed,
                     got.removed);
            errors++;
          end
          if (got.occ != want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, got.occ);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               pending_outcomes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: changes stall style every so often, one long hold-off on request
  initial begin : sink
    int mode;
    int span;
    int k;
    int h;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(30, 200);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_off_req && !hold_done) begin
          hold_done = 1'b1;
          m_tready <= 1'b0;
          for (h = 0; h < HOLD_CYCLES; h++) @(posedge clk);
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (k % 3 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int insert_pct [PHASES];
    int ph;
    int n;
    int b;
    int burst;
    logic act;
    insert_pct = '{70, 30, 55, 85, 15, 50};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_ops[i]) begin
      send_op(directed_ops[i].act, directed_ops[i].val, directed_ops[i].known,
              '{directed_ops[i].status, directed_ops[i].removed, directed_ops[i].occ});
    end
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      n = 0;
      while (n < PHASE_ITEMS) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
        for (b = 0; b < burst && n < PHASE_ITEMS; b++) begin
          // receiver holds off while the sender keeps offering
          if (ph == 2 && n == PHASE_ITEMS / 2) hold_off_req <= 1'b1;
          act = ($urandom_range(1, 100) <= insert_pct[ph]) ? ACT_INSERT : ACT_DELETE;
          send_op(act, pick_value(), 1'b0, '0);
          n++;
        end
        go_idle($urandom_range(1, 10));
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d inserts and %0d deletes, %0d results checked", n_insert, n_delete,
             checked);
    $display("queue reported full %0d times and empty %0d times", n_full, n_empty);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_store.sv
hw/rtl/sorted_priority_queue.sv
verif/sorted_priority_queue_test.sv
